[hdl/binary_to_decimal_ascii_top_macros.svh]
// assertion helpers used by b2da_ctrl
`ifndef BINARY_TO_DECIMAL_ASCII_TOP_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_TOP_MACROS_SVH

// condition holds in the same cycle as the trigger
`define B2DA_ASSERT_SAME(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define B2DA_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

[hdl/b2da_pkg.sv]
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared constants and controller/datapath interface types for the
// binary to decimal text converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

  localparam int DEFAULT_VALUE_BITS = 31;
  localparam int ASCII_ZERO         = 48;
  localparam int DIGIT_W            = 4;
  localparam int CHAR_W             = 6;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic dabble;
    logic digit_shift;
    logic out_load;
    logic out_last;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic top_zero;
  } stat_t;

endpackage

[hdl/b2da_dp.sv]
// ----------------------------------------------------------------------------
// b2da_dp
// Shift-and-add-3 conversion register, digit scan shifter and output word
// register.
// ----------------------------------------------------------------------------
module b2da_dp #(
  parameter int VALUE_BITS = b2da_pkg::DEFAULT_VALUE_BITS,
  parameter int NUM_DIGITS = 10
) (
  input  logic                           clk,
  input  logic [VALUE_BITS-1:0]          value,
  input  b2da_pkg::cmd_t                 cmd,
  output b2da_pkg::stat_t                stat,
  output logic [b2da_pkg::CHAR_W-1:0]    digit_char,
  output logic                           last
);
  import b2da_pkg::*;

  localparam int BCD_W = NUM_DIGITS * DIGIT_W;

  logic [VALUE_BITS-1:0] bin;
  logic [BCD_W-1:0]      bcd;
  logic [BCD_W-1:0]      bcd_adj;
  logic [DIGIT_W-1:0]    top_digit;

  // add 3 to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  assign top_digit     = bcd[BCD_W-1 -: DIGIT_W];
  assign stat.top_zero = (top_digit == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin <= value;
      bcd <= '0;
    end else if (cmd.dabble) begin
      {bcd, bin} <= {bcd_adj[BCD_W-2:0], bin, 1'b0};
    end else if (cmd.digit_shift) begin
      bcd <= {bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end
    if (cmd.out_load) begin
      digit_char <= CHAR_W'(ASCII_ZERO) + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
      last       <= cmd.out_last;
    end
  end

endmodule

[hdl/b2da_ctrl.sv]
// ----------------------------------------------------------------------------
// b2da_ctrl
// Sequencer: accepts a value, runs one conversion step per input bit, then
// scans the digits, dropping leading zeros and handing words to the output.
// ----------------------------------------------------------------------------
module b2da_ctrl #(
  parameter int VALUE_BITS = b2da_pkg::DEFAULT_VALUE_BITS,
  parameter int NUM_DIGITS = 10
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            value_valid,
  output logic            value_ready,
  output logic            digit_valid,
  input  logic            digit_ready,
  output b2da_pkg::cmd_t  cmd,
  input  b2da_pkg::stat_t stat
);
  import b2da_pkg::*;
  `include "binary_to_decimal_ascii_top_macros.svh"

  localparam int BIT_W = $clog2(VALUE_BITS);
  localparam int DIG_W = $clog2(NUM_DIGITS + 1);

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_EMIT} state_t;

  state_t             state;
  logic [BIT_W-1:0]   bit_cnt;
  logic [DIG_W-1:0]   dig_cnt;
  logic               started;
  logic               skip;
  logic               emit;
  logic               out_free;

  assign value_ready = (state == S_IDLE);

  always_comb begin
    out_free = !digit_valid || digit_ready;
    // leading zero, and not the final digit position
    skip = (state == S_EMIT) && stat.top_zero && !started && (dig_cnt != DIG_W'(1));
    emit = (state == S_EMIT) && !skip && out_free;
    cmd.load        = value_valid && (state == S_IDLE);
    cmd.dabble      = (state == S_CONV);
    cmd.digit_shift = skip || emit;
    cmd.out_load    = emit;
    cmd.out_last    = (dig_cnt == DIG_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      bit_cnt     <= '0;
      dig_cnt     <= '0;
      started     <= 1'b0;
      digit_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (value_valid) begin
            state   <= S_CONV;
            bit_cnt <= BIT_W'(VALUE_BITS - 1);
            started <= 1'b0;
          end
        end
        S_CONV: begin
          if (bit_cnt == '0) begin
            state   <= S_EMIT;
            dig_cnt <= DIG_W'(NUM_DIGITS);
          end else begin
            bit_cnt <= bit_cnt - BIT_W'(1);
          end
        end
        S_EMIT: begin
          if (skip || emit) begin
            dig_cnt <= dig_cnt - DIG_W'(1);
          end
          if (emit) begin
            started <= 1'b1;
            if (dig_cnt == DIG_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (emit) begin
        digit_valid <= 1'b1;
      end else if (digit_ready) begin
        digit_valid <= 1'b0;
      end
    end
  end

  `B2DA_ASSERT_NEXT(a_accept_starts_conv, value_valid && value_ready, state == S_CONV, "accepted word did not start conversion")
  `B2DA_ASSERT_SAME(a_no_overwrite, cmd.out_load, !digit_valid || digit_ready, "pending output word overwritten")
  `B2DA_ASSERT_NEXT(a_last_ends_run, cmd.out_load && cmd.out_last, state == S_IDLE && digit_valid, "run did not end on last digit")
  `B2DA_ASSERT_SAME(a_shift_only_in_scan, state != S_EMIT, !cmd.digit_shift && !cmd.out_load, "digit shift outside scan")

endmodule

[hdl/binary_to_decimal_ascii_top.sv]
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_top
// Converts an unsigned integer to its decimal ASCII digits, most significant
// first, no leading zeros, with the final digit flagged.
//
//   channel  handshake                  payload
//   value    value_valid/value_ready    value[VALUE_BITS-1:0]
//   digit    digit_valid/digit_ready    digit_char[5:0], last
//
// A value passes through one accept step, one shift-and-add-3 step per input
// bit, then one step per digit position of the scan, leading zeros included.
// An output stall holds the scan on the next digit to be sent; the value
// side stays closed until the last digit is in the output register.
// Synchronous active-high reset clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_top #(
  parameter int VALUE_BITS = b2da_pkg::DEFAULT_VALUE_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        value_valid,
  output logic                        value_ready,
  input  logic [VALUE_BITS-1:0]       value,
  output logic                        digit_valid,
  input  logic                        digit_ready,
  output logic [b2da_pkg::CHAR_W-1:0] digit_char,
  output logic                        last
);
  import b2da_pkg::*;

  // decimal length of the largest value: floor(bits * log10 2) + 1
  localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;

  cmd_t  cmd;
  stat_t stat;

  b2da_ctrl #(
    .VALUE_BITS (VALUE_BITS),
    .NUM_DIGITS (NUM_DIGITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .value_valid (value_valid),
    .value_ready (value_ready),
    .digit_valid (digit_valid),
    .digit_ready (digit_ready),
    .cmd         (cmd),
    .stat        (stat)
  );

  b2da_dp #(
    .VALUE_BITS (VALUE_BITS),
    .NUM_DIGITS (NUM_DIGITS)
  ) u_dp (
    .clk        (clk),
    .value      (value),
    .cmd        (cmd),
    .stat       (stat),
    .digit_char (digit_char),
    .last       (last)
  );

endmodule
